// File: rtl/spq_pkg.sv
// Shared constants, codes and types of the sorted priority task queue.
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int ID_W  = 16;
	localparam int PRI_W = 8;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Command broadcast to every cell; the strobes are already qualified.
	typedef struct packed {
		logic             ins;
		logic             pop;
		logic             rem;
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} spq_ctrl_t;

endpackage

// File: rtl/sorted_priority_task_queue_top.sv
// Top level of the sorted priority task queue: cell row, task count and result register.
//
// Input channel: opcode, task_id and priority_req move in one transaction when
// in_valid is high and in_stall is low. Insert places the task behind every
// held task of equal or higher priority; pop returns the head; remove deletes
// the first task from the head with a matching identifier.
// Output channel: status, out_id, out_priority and occupancy move when
// out_valid is high and out_stall is low. Every input transaction yields
// exactly one result.
// The result is registered at the edge that accepts the command. One command
// per cycle is taken while the result register is empty or being drained;
// every cell compares and shifts in that same cycle, and a remove resolves
// its first match along the row of cells.
// When the receiver stalls with a result held, in_stall rises and the
// result stays put until taken.
// Reset empties the queue and clears out_valid and status, not the payload;
// the slot contents are not cleared and are never read before they are written.
module sorted_priority_task_queue_top import spq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       opcode,
	input  logic [ID_W-1:0]  task_id,
	input  logic [PRI_W-1:0] priority_req,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [ID_W-1:0]  out_id,
	output logic [PRI_W-1:0] out_priority,
	output logic [CNT_W-1:0] occupancy
);

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [ID_W-1:0]  out_id_q;
	logic [PRI_W-1:0] out_pri_q;

	logic             accept;
	logic             full;
	logic             empty;
	spq_ctrl_t        ctrl;

	logic [ID_W-1:0]  cell_id  [DEPTH];
	logic [PRI_W-1:0] cell_pri [DEPTH];
	logic             cell_ge  [DEPTH];
	logic             found    [DEPTH+1];
	logic [ID_W-1:0]  sel_id   [DEPTH+1];
	logic [PRI_W-1:0] sel_pri  [DEPTH+1];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	assign ctrl.ins = accept && (opcode == OP_INSERT) && !full;
	assign ctrl.pop = accept && (opcode == OP_POP) && !empty;
	assign ctrl.rem = accept && (opcode == OP_REMOVE);
	assign ctrl.id  = task_id;
	assign ctrl.pri = priority_req;

	assign found[0]   = 1'b0;
	assign sel_id[0]  = '0;
	assign sel_pri[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             p_ge;
		logic [ID_W-1:0]  p_id;
		logic [PRI_W-1:0] p_pri;
		logic [ID_W-1:0]  n_id;
		logic [PRI_W-1:0] n_pri;

		if (i == 0) begin : g_head
			assign p_ge  = 1'b1;
			assign p_id  = '0;
			assign p_pri = '0;
		end else begin : g_body
			assign p_ge  = cell_ge[i-1];
			assign p_id  = cell_id[i-1];
			assign p_pri = cell_pri[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_id  = cell_id[i];
			assign n_pri = cell_pri[i];
		end else begin : g_inner
			assign n_id  = cell_id[i+1];
			assign n_pri = cell_pri[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.active      (CNT_W'(i) < count_q),
			.prev_ge     (p_ge),
			.prev_id     (p_id),
			.prev_pri    (p_pri),
			.next_id     (n_id),
			.next_pri    (n_pri),
			.found_in    (found[i]),
			.sel_id_in   (sel_id[i]),
			.sel_pri_in  (sel_pri[i]),
			.ge          (cell_ge[i]),
			.found_out   (found[i+1]),
			.sel_id_out  (sel_id[i+1]),
			.sel_pri_out (sel_pri[i+1]),
			.id          (cell_id[i]),
			.pri         (cell_pri[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				status_q    <= ST_OK;
				case (opcode)
					OP_INSERT: begin
						if (full) begin
							status_q <= ST_FULL;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
					OP_POP: begin
						if (empty) begin
							status_q <= ST_EMPTY;
						end else begin
							count_q <= count_q - 1'b1;
						end
					end
					OP_REMOVE: begin
						if (empty) begin
							status_q <= ST_EMPTY;
						end else if (!found[DEPTH]) begin
							status_q <= ST_NOTFOUND;
						end else begin
							count_q <= count_q - 1'b1;
						end
					end
					default: begin
						status_q <= ST_OK;
					end
				endcase
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the reported task is the head for pop, the match for remove.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (ctrl.pop) begin
				out_id_q  <= cell_id[0];
				out_pri_q <= cell_pri[0];
			end else if (ctrl.rem) begin
				out_id_q  <= sel_id[DEPTH];
				out_pri_q <= sel_pri[DEPTH];
			end else begin
				out_id_q  <= '0;
				out_pri_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_id       = out_id_q;
	assign out_priority = out_pri_q;
	assign occupancy    = count_q;

endmodule

// File: rtl/spq_cell.sv
// One slot of the sorted queue: holds a task and shifts it toward its neighbors.
module spq_cell import spq_pkg::*; (
	input  logic             clk,
	input  spq_ctrl_t        ctrl,
	input  logic             active,
	input  logic             prev_ge,
	input  logic [ID_W-1:0]  prev_id,
	input  logic [PRI_W-1:0] prev_pri,
	input  logic [ID_W-1:0]  next_id,
	input  logic [PRI_W-1:0] next_pri,
	input  logic             found_in,
	input  logic [ID_W-1:0]  sel_id_in,
	input  logic [PRI_W-1:0] sel_pri_in,
	output logic             ge,
	output logic             found_out,
	output logic [ID_W-1:0]  sel_id_out,
	output logic [PRI_W-1:0] sel_pri_out,
	output logic [ID_W-1:0]  id,
	output logic [PRI_W-1:0] pri
);

	logic [ID_W-1:0]  id_q;
	logic [PRI_W-1:0] pri_q;
	logic             match;

	assign ge    = active && (pri_q >= ctrl.pri);
	assign match = active && (id_q == ctrl.id);
	assign found_out = found_in | match;

	// The first match from the head wins; later cells pass its value along.
	always_comb begin
		if (found_in) begin
			sel_id_out  = sel_id_in;
			sel_pri_out = sel_pri_in;
		end else if (match) begin
			sel_id_out  = id_q;
			sel_pri_out = pri_q;
		end else begin
			sel_id_out  = '0;
			sel_pri_out = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !ge) begin
			if (prev_ge) begin
				id_q  <= ctrl.id;
				pri_q <= ctrl.pri;
			end else begin
				id_q  <= prev_id;
				pri_q <= prev_pri;
			end
		end else if (ctrl.pop || (ctrl.rem && found_out)) begin
			id_q  <= next_id;
			pri_q <= next_pri;
		end
	end

	assign id  = id_q;
	assign pri = pri_q;

endmodule

// File: test/spq_result_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted priority task queue: tracks the held tasks and checks every result.
module spq_result_checker import spq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [1:0]       opcode,
	input  logic [ID_W-1:0]  task_id,
	input  logic [PRI_W-1:0] priority_req,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [1:0]       status,
	input  logic [ID_W-1:0]  out_id,
	input  logic [PRI_W-1:0] out_priority,
	input  logic [CNT_W-1:0] occupancy,
	output int               failures,
	output int               pending
);

	typedef struct {
		status_t          st;
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
		logic [CNT_W-1:0] occ;
	} task_result_t;

	logic [ID_W-1:0]  held_ids  [DEPTH];
	logic [PRI_W-1:0] held_pris [DEPTH];
	int               held_count;
	task_result_t     awaited_results [$];

	task automatic drop_at(input int pos);
		for (int k = pos; k + 1 < held_count; k++) begin
			held_ids[k]  = held_ids[k + 1];
			held_pris[k] = held_pris[k + 1];
		end
		held_count--;
	endtask

	task automatic serve_command(input logic [1:0] op, input logic [ID_W-1:0] id,
			input logic [PRI_W-1:0] pri, output task_result_t res);
		int pos;
		res.st  = ST_OK;
		res.id  = '0;
		res.pri = '0;
		pos     = 0;
		case (op)
			OP_INSERT: begin
				if (held_count >= DEPTH) begin
					res.st = ST_FULL;
				end else begin
					// A new task goes behind every task of equal or higher priority.
					while (pos < held_count && held_pris[pos] >= pri)
						pos++;
					for (int k = held_count; k > pos; k--) begin
						held_ids[k]  = held_ids[k - 1];
						held_pris[k] = held_pris[k - 1];
					end
					held_ids[pos]  = id;
					held_pris[pos] = pri;
					held_count++;
				end
			end
			OP_POP: begin
				if (held_count == 0) begin
					res.st = ST_EMPTY;
				end else begin
					res.id  = held_ids[0];
					res.pri = held_pris[0];
					drop_at(0);
				end
			end
			OP_REMOVE: begin
				if (held_count == 0) begin
					res.st = ST_EMPTY;
				end else begin
					while (pos < held_count && held_ids[pos] != id)
						pos++;
					if (pos >= held_count) begin
						res.st = ST_NOTFOUND;
					end else begin
						res.id  = held_ids[pos];
						res.pri = held_pris[pos];
						drop_at(pos);
					end
				end
			end
			default: begin
			end
		endcase
		res.occ = held_count[CNT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		task_result_t want;
		task_result_t fresh;
		if (!arst_n) begin
			held_count = 0;
			awaited_results.delete();
			failures = 0;
		end else begin
			// The result taken at this edge belongs to an earlier command, so check it first.
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%t unexpected result: status %0d id %h pri %0d occ %0d",
							$realtime, status, out_id, out_priority, occupancy);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.st || out_id !== want.id ||
							out_priority !== want.pri || occupancy !== want.occ) begin
						failures++;
						if (failures <= 10)
							$display({"%t mismatch: expected status %0d id %h pri %0d occ %0d,",
								" got status %0d id %h pri %0d occ %0d"}, $realtime,
								want.st, want.id, want.pri, want.occ,
								status, out_id, out_priority, occupancy);
					end
				end
			end
			if (in_valid && !in_stall) begin
				serve_command(opcode, task_id, priority_req, fresh);
				awaited_results.push_back(fresh);
			end
		end
		pending = awaited_results.size();
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the sorted priority task queue: clock, reset, stimulus and verdict.
module tb;
	import spq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1876;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       opcode;
	logic [ID_W-1:0]  task_id;
	logic [PRI_W-1:0] priority_req;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       status;
	logic [ID_W-1:0]  out_id;
	logic [PRI_W-1:0] out_priority;
	logic [CNT_W-1:0] occupancy;
	int               failures;
	int               pending;
	int               sender_idle_pct = 0;
	int               stall_pct = 0;
	int               idle_cycles;
	logic [ID_W-1:0]  recent_ids [$];

	sorted_priority_task_queue_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.task_id      (task_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_id       (out_id),
		.out_priority (out_priority),
		.occupancy    (occupancy)
	);

	spq_result_checker checker_inst (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.task_id      (task_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_id       (out_id),
		.out_priority (out_priority),
		.occupancy    (occupancy),
		.failures     (failures),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Ends the run when no transaction moves on either channel for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_command(input opcode_t op, input logic [ID_W-1:0] id,
			input logic [PRI_W-1:0] pri);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		task_id      <= id;
		priority_req <= pri;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_INSERT) begin
			recent_ids.push_back(id);
			if (recent_ids.size() > 32)
				void'(recent_ids.pop_front());
		end
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		case ($urandom_range(3))
			0: pick_id = ($urandom_range(1) == 0) ? ID_W'($urandom_range(3)) : '1;
			default: pick_id = ID_W'($urandom);
		endcase
	endfunction

	function automatic logic [PRI_W-1:0] pick_priority();
		case ($urandom_range(3))
			0: pick_priority = PRI_W'($urandom_range(3));
			1: pick_priority = 8'hFF - PRI_W'($urandom_range(1));
			default: pick_priority = PRI_W'($urandom);
		endcase
	endfunction

	initial begin
		int insert_pct;
		int roll;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_INSERT;
		task_id      = '0;
		priority_req = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty queue, then fill it with ties, duplicate identifiers and extreme values.
		send_command(OP_POP, 16'h0000, 8'h00);
		send_command(OP_REMOVE, 16'hFFFF, 8'h00);
		send_command(OP_INSERT, 16'h0000, 8'h00);
		send_command(OP_INSERT, 16'hFFFF, 8'hFF);
		send_command(OP_INSERT, 16'h0001, 8'h80);
		send_command(OP_INSERT, 16'h0002, 8'h80);
		send_command(OP_INSERT, 16'h0003, 8'h80);
		send_command(OP_INSERT, 16'h0001, 8'hFF);
		send_command(OP_INSERT, 16'h0004, 8'h00);
		for (int i = 0; i < 9; i++)
			send_command(OP_INSERT, 16'h0100 + ID_W'(i), PRI_W'(i * 31));
		send_command(OP_INSERT, 16'hBEEF, 8'h55);
		send_command(OP_REMOVE, 16'h7777, 8'h00);
		send_command(OP_REMOVE, 16'h0001, 8'h00);
		send_command(OP_REMOVE, 16'hFFFF, 8'h00);
		send_command(OP_POP, 16'h0000, 8'h00);
		send_command(OP_POP, 16'h0000, 8'h00);

		insert_pct = 45;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 85; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 85; end
				default: begin sender_idle_pct = 36; stall_pct = 36; end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				// Swing between filling and draining so both full and empty are reached.
				if (n % 40 == 0) begin
					case ($urandom_range(2))
						0: insert_pct = 75;
						1: insert_pct = 20;
						default: insert_pct = 45;
					endcase
				end
				roll = $urandom_range(99);
				if (roll < insert_pct)
					send_command(OP_INSERT, pick_id(), pick_priority());
				else if ($urandom_range(1) == 0)
					send_command(OP_POP, pick_id(), pick_priority());
				else if (recent_ids.size() > 0 && $urandom_range(9) < 7)
					send_command(OP_REMOVE,
						recent_ids[$urandom_range(recent_ids.size() - 1)], pick_priority());
				else
					send_command(OP_REMOVE, pick_id(), pick_priority());
			end
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
